// ===== rtl/core/sam_pkg.sv =====
// Shared types and constants of the spectral angle mapper.
// Used by sam_front, sam_back and the top level; no dependencies.
`default_nettype none
package sam_pkg;

  localparam int unsigned ACC_W        = 42;
  localparam int unsigned WIN_W        = 11;
  localparam int unsigned ANGLE_W      = 16;
  localparam int unsigned CORDIC_STEPS = 21;
  localparam int unsigned DIV_BASE     = ACC_W + 30;

  localparam logic REG_WINDOW_START = 1'b0;
  localparam logic REG_WINDOW_END   = 1'b1;

  localparam logic [WIN_W-1:0] WIN_START_RST = 11'd0;
  localparam logic [WIN_W-1:0] WIN_END_RST   = 11'd1024;

  typedef struct packed {
    logic [ACC_W-1:0] dot;
    logic [ACC_W-1:0] ea;
    logic [ACC_W-1:0] eb;
  } job_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               degenerate;
  } res_t;

  function automatic logic signed [23:0] atan_val(input logic [4:0] i);
    logic signed [23:0] v;
    case (i)
      5'd0:    v = 24'sd823550;
      5'd1:    v = 24'sd486170;
      5'd2:    v = 24'sd256879;
      5'd3:    v = 24'sd130396;
      5'd4:    v = 24'sd65451;
      5'd5:    v = 24'sd32757;
      5'd6:    v = 24'sd16383;
      default: v = 24'sd8192 >>> (i - 5'd7);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/spectral_angle_mapper.sv =====
// Spectral angle mapper: bands enter at one per cycle while the job queue is not full;
// the front accumulates one spectrum pair per last_band item and queues it; the back
// end takes a new spectrum only when idle and works through normalize, three roots,
// 92 to 132 divide steps and 21 CORDIC steps; a degenerate spectrum skips to the
// result. Two spectra may wait between the parts, two results at the output.
// Reset clears the counters, accumulators and queues; windows return to 0 and 1024.
`default_nettype none
module spectral_angle_mapper #(
  parameter int unsigned MAX_BANDS   = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] sample_a_i,
  input  wire logic [15:0] sample_b_i,
  input  wire logic        last_band_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      angle_o,
  output logic             degenerate_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned JW = $bits(sam_pkg::job_t);
  localparam int unsigned RW = $bits(sam_pkg::res_t);

  logic [sam_pkg::WIN_W-1:0] win_start_q, win_end_q;
  logic          accept, job_push, job_full, job_empty, job_pop;
  logic          res_push, res_full;
  sam_pkg::job_t job_in, job_out;
  sam_pkg::res_t res_in, res_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sam_pkg::REG_WINDOW_END) ? 32'(win_end_q) : 32'(win_start_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= sam_pkg::WIN_START_RST;
      win_end_q   <= sam_pkg::WIN_END_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == sam_pkg::REG_WINDOW_END) begin
        win_end_q <= pwdata[sam_pkg::WIN_W-1:0];
      end else begin
        win_start_q <= pwdata[sam_pkg::WIN_W-1:0];
      end
    end
  end

  assign full   = job_full;
  assign accept = push & ~job_full;

  sam_front #(
    .MAX_BANDS  (MAX_BANDS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(accept),
    .sample_a_i  (sample_a_i),
    .sample_b_i  (sample_b_i),
    .last_band_i (last_band_i),
    .win_start_i (win_start_q),
    .win_end_i   (win_end_q),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  sam_fifo #(.WIDTH(JW), .DEPTH(2)) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .data_o (job_out),
    .empty_o(job_empty)
  );

  sam_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(~job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  sam_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign angle_o      = res_out.angle;
  assign degenerate_o = res_out.degenerate;
endmodule
`default_nettype wire

// ===== rtl/core/sam_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// No dependencies.
`default_nettype none
module sam_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sam_front.sv =====
// Band counter and windowed dot/energy accumulators; emits one job per spectrum.
// Depends on sam_pkg.
`default_nettype none
module sam_front #(
  parameter int unsigned MAX_BANDS   = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      item_valid_i,
  input  wire logic [15:0]               sample_a_i,
  input  wire logic [15:0]               sample_b_i,
  input  wire logic                      last_band_i,
  input  wire logic [sam_pkg::WIN_W-1:0] win_start_i,
  input  wire logic [sam_pkg::WIN_W-1:0] win_end_i,
  output logic                           job_push_o,
  output sam_pkg::job_t                  job_o
);
  localparam int unsigned IW = $clog2(MAX_BANDS + 1);
  localparam int unsigned XW = (IW > sam_pkg::WIN_W) ? IW : sam_pkg::WIN_W;
  localparam logic [15:0] SMASK = 16'((32'h1 << SAMPLE_BITS) - 1);
  localparam int unsigned AW = sam_pkg::ACC_W;

  logic [IW-1:0] idx_q;
  logic [AW-1:0] dot_q, ea_q, eb_q, dot_d, ea_d, eb_d;
  logic [15:0]   a, b;
  logic          in_win;

  function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] acc,
                                            input logic [31:0] v);
    logic [AW:0] s;
    s = {1'b0, acc} + (AW + 1)'(v);
    return s[AW] ? '1 : s[AW-1:0];
  endfunction

  assign a = sample_a_i & SMASK;
  assign b = sample_b_i & SMASK;
  assign in_win = (idx_q < IW'(MAX_BANDS)) &&
                  (XW'(idx_q) >= XW'(win_start_i)) &&
                  (XW'(idx_q) < XW'(win_end_i));

  assign dot_d = in_win ? sat_add(dot_q, 32'(a) * 32'(b)) : dot_q;
  assign ea_d  = in_win ? sat_add(ea_q, 32'(a) * 32'(a)) : ea_q;
  assign eb_d  = in_win ? sat_add(eb_q, 32'(b) * 32'(b)) : eb_q;

  assign job_push_o = item_valid_i & last_band_i;
  assign job_o.dot  = dot_d;
  assign job_o.ea   = ea_d;
  assign job_o.eb   = eb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      dot_q <= '0;
      ea_q  <= '0;
      eb_q  <= '0;
    end else if (item_valid_i) begin
      if (last_band_i) begin
        idx_q <= '0;
        dot_q <= '0;
        ea_q  <= '0;
        eb_q  <= '0;
      end else begin
        dot_q <= dot_d;
        ea_q  <= ea_d;
        eb_q  <= eb_d;
        if (idx_q < IW'(MAX_BANDS)) begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sam_back.sv =====
// Angle engine: normalize, shared bit-serial square root, restoring divide, CORDIC.
// Depends on sam_pkg.
`default_nettype none
module sam_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  sam_pkg::job_t      job_i,
  output logic               job_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output sam_pkg::res_t      res_o
);
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_NORM   = 4'd1;
  localparam logic [3:0] ST_SQRT_A = 4'd2;
  localparam logic [3:0] ST_SQRT_B = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_DIV    = 4'd5;
  localparam logic [3:0] ST_CSQ    = 4'd6;
  localparam logic [3:0] ST_SQRT_C = 4'd7;
  localparam logic [3:0] ST_CORDIC = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [63:0] ONE_Q60  = 64'h1000_0000_0000_0000;

  logic [3:0]  state_q;
  logic [41:0] dot_q;
  logic [63:0] ea_q, eb_q;
  logic [4:0]  ka_q, kb_q;
  logic [63:0] sv_q, sres_q;
  logic [4:0]  sj_q;
  logic [31:0] sa_q, sb_q;
  logic [63:0] p_q, r_q;
  logic [31:0] q_q;
  logic [7:0]  n_q;
  logic [30:0] c_q;
  logic signed [33:0] x_q, y_q;
  logic signed [23:0] z_q;
  logic [4:0]  i_q;
  sam_pkg::res_t res_q;

  logic [63:0] sbit, scmp, sv_n, sres_n;
  logic        sge;
  logic [63:0] rin, r_n;
  logic        dge;
  logic [31:0] q_n;
  logic [7:0]  div_last;
  logic [33:0] xmag, ymag;
  logic signed [33:0] dx, dy;

  function automatic logic [24:0] zpos_next(input logic signed [33:0] y,
                                            input logic signed [23:0] z,
                                            input logic [4:0] i);
    logic signed [23:0] zn;
    zn = y[33] ? z - sam_pkg::atan_val(i) : z + sam_pkg::atan_val(i);
    return zn[23] ? 25'd0 : 25'(zn);
  endfunction

  assign sbit   = 64'(1) << {sj_q, 1'b0};
  assign scmp   = sres_q + sbit;
  assign sge    = (sv_q >= scmp);
  assign sv_n   = sge ? sv_q - scmp : sv_q;
  assign sres_n = sge ? (sres_q >> 1) + sbit : (sres_q >> 1);

  assign rin      = {r_q[62:0], dot_q[41]};
  assign dge      = (rin >= p_q);
  assign r_n      = dge ? rin - p_q : rin;
  assign q_n      = ({q_q[30:0], dge} > ONE_Q30) ? ONE_Q30 + 32'd1 : {q_q[30:0], dge};
  assign div_last = 8'(sam_pkg::DIV_BASE - 1) + 8'(ka_q) + 8'(kb_q);

  assign ymag = y_q[33] ? 34'(-y_q) : 34'(y_q);
  assign xmag = x_q[33] ? 34'(-x_q) : 34'(x_q);
  assign dx   = y_q[33] ? -$signed(ymag >> i_q) : $signed(ymag >> i_q);
  assign dy   = x_q[33] ? -$signed(xmag >> i_q) : $signed(xmag >> i_q);

  assign job_pop_o  = (state_q == ST_IDLE) && job_valid_i && !res_full_i;
  assign res_push_o = (state_q == ST_DONE);
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (job_pop_o) begin
            if (job_i.ea == '0 || job_i.eb == '0) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (ea_q[63:60] != 4'd0 && eb_q[63:60] != 4'd0) begin
            state_q <= ST_SQRT_A;
          end
        end
        ST_SQRT_A: if (sj_q == 5'd0) state_q <= ST_SQRT_B;
        ST_SQRT_B: if (sj_q == 5'd0) state_q <= ST_MUL;
        ST_MUL:    state_q <= ST_DIV;
        ST_DIV:    if (n_q == div_last) state_q <= ST_CSQ;
        ST_CSQ:    state_q <= ST_SQRT_C;
        ST_SQRT_C: if (sj_q == 5'd0) state_q <= ST_CORDIC;
        ST_CORDIC: if (i_q == 5'(sam_pkg::CORDIC_STEPS - 1)) state_q <= ST_DONE;
        ST_DONE:   state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dot_q <= job_i.dot;
        ea_q  <= 64'(job_i.ea);
        eb_q  <= 64'(job_i.eb);
        ka_q  <= '0;
        kb_q  <= '0;
        res_q <= '{angle: '0, degenerate: 1'b1};
      end
      ST_NORM: begin
        if (ea_q[63:60] == 4'd0) begin
          ea_q <= ea_q << 2;
          ka_q <= ka_q + 5'd1;
        end
        if (eb_q[63:60] == 4'd0) begin
          eb_q <= eb_q << 2;
          kb_q <= kb_q + 5'd1;
        end
        sv_q   <= ea_q;
        sres_q <= '0;
        sj_q   <= 5'd31;
      end
      ST_SQRT_A: begin
        sv_q   <= sv_n;
        sres_q <= sres_n;
        sj_q   <= sj_q - 5'd1;
        if (sj_q == 5'd0) begin
          sa_q   <= sres_n[31:0];
          sv_q   <= eb_q;
          sres_q <= '0;
          sj_q   <= 5'd31;
        end
      end
      ST_SQRT_B: begin
        sv_q   <= sv_n;
        sres_q <= sres_n;
        sj_q   <= sj_q - 5'd1;
        if (sj_q == 5'd0) begin
          sb_q <= sres_n[31:0];
        end
      end
      ST_MUL: begin
        p_q <= sa_q * sb_q;
        r_q <= '0;
        q_q <= '0;
        n_q <= '0;
      end
      ST_DIV: begin
        r_q   <= r_n;
        q_q   <= q_n;
        dot_q <= {dot_q[40:0], 1'b0};
        n_q   <= n_q + 8'd1;
        c_q   <= (q_n > ONE_Q30) ? 31'(ONE_Q30) : q_n[30:0];
      end
      ST_CSQ: begin
        sv_q   <= ONE_Q60 - 64'(c_q) * 64'(c_q);
        sres_q <= '0;
        sj_q   <= 5'd31;
      end
      ST_SQRT_C: begin
        sv_q   <= sv_n;
        sres_q <= sres_n;
        sj_q   <= sj_q - 5'd1;
        x_q    <= $signed({3'b000, c_q});
        y_q    <= $signed({2'b00, sres_n[31:0]});
        z_q    <= '0;
        i_q    <= '0;
      end
      ST_CORDIC: begin
        if (!y_q[33]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + sam_pkg::atan_val(i_q);
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - sam_pkg::atan_val(i_q);
        end
        i_q <= i_q + 5'd1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
    if (state_q == ST_CORDIC && i_q == 5'(sam_pkg::CORDIC_STEPS - 1)) begin
      res_q.degenerate <= 1'b0;
      res_q.angle      <= 16'((zpos_next(y_q, z_q, i_q) + 25'd32) >> 6);
    end
  end
endmodule
`default_nettype wire
